### hdl/kp_pkg.sv
// shared types and constants of the kinetic preconditioner
package kp_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_K_X         = 2'd0,
    CFG_K_Y         = 2'd1,
    CFG_K_Z         = 2'd2,
    CFG_INV_KINETIC = 2'd3
  } kp_cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // reset value of inv_kinetic, 1.0 in Q8.24
  localparam logic [31:0] INV_KIN_RST = 32'h0100_0000;

  // constant term of the numerator, 27.0 in Q.24
  localparam logic [51:0] NUM_C27 = 52'd27 << 24;

  // ratio of exactly 1.0 in Q1.30
  localparam logic [30:0] RATIO_ONE = 31'h4000_0000;

  // pipeline layout
  localparam int unsigned DIV_BITS   = 30;
  localparam int unsigned DIV_S      = 11;
  localparam int unsigned MUL_S      = DIV_S + DIV_BITS;
  localparam int unsigned OUT_S      = MUL_S + 1;
  localparam int unsigned NUM_STAGES = OUT_S + 1;

endpackage

### hdl/kp_if.sv
// valid/ready channels of the kinetic preconditioner
interface kp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] g_x;
  logic signed [23:0] g_y;
  logic signed [23:0] g_z;
  logic signed [31:0] xi_re;
  logic signed [31:0] xi_im;

  modport source (output valid, g_x, g_y, g_z, xi_re, xi_im, input ready);
  modport sink   (input valid, g_x, g_y, g_z, xi_re, xi_im, output ready);
endinterface

interface kp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eta_re;
  logic signed [31:0] eta_im;

  modport source (output valid, eta_re, eta_im, input ready);
  modport sink   (input valid, eta_re, eta_im, output ready);
endinterface

### hdl/kinetic_preconditioner_core.sv
// top level of the kinetic preconditioner pipeline
// One coefficient enters per cycle while the output side keeps taking transfers. The
// pipeline has 43 register stages: G+k, the squares, |G+k|^2, the scaling by
// inv_kinetic, the powers of x (x^2 one multiplier pass, x^3 and x^4 each a split
// 32-bit multiplier pass and an add stage), numerator and denominator, a restoring
// divider with one quotient bit per stage (30 stages), the complex scaling and the
// output register. Each stage stalls only when the stage after it is full and
// stalled, so bubbles close up and an input transfer is taken while a result waits.
// Configuration writes take effect at once and are meant for an empty pipeline.
module kinetic_preconditioner_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [kp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  kp_in_if.sink                          in_ch,
  kp_out_if.source                       out_ch
);

  localparam int unsigned NS = kp_pkg::NUM_STAGES;
  localparam int unsigned DB = kp_pkg::DIV_BITS;
  localparam int unsigned DS = kp_pkg::DIV_S;
  localparam int unsigned MS = kp_pkg::MUL_S;
  localparam int unsigned OS = kp_pkg::OUT_S;

  // configuration registers
  logic signed [23:0] k_x_r, k_y_r, k_z_r;
  logic [31:0]        inv_kin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_x_r     <= '0;
      k_y_r     <= '0;
      k_z_r     <= '0;
      inv_kin_r <= kp_pkg::INV_KIN_RST;
    end else if (cfg_we) begin
      case (kp_pkg::kp_cfg_idx_t'(cfg_idx))
        kp_pkg::CFG_K_X:         k_x_r     <= cfg_wdata[23:0];
        kp_pkg::CFG_K_Y:         k_y_r     <= cfg_wdata[23:0];
        kp_pkg::CFG_K_Z:         k_z_r     <= cfg_wdata[23:0];
        kp_pkg::CFG_INV_KINETIC: inv_kin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage valids and advance chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   adv;

  assign adv[NS] = out_ch.ready;
  assign v_in    = {v_r[NS-2:0], in_ch.valid};

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_adv
      assign adv[s] = !v_r[s] || adv[s+1];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  assign in_ch.ready = adv[0];

  // gradient coefficient travels alongside the arithmetic
  logic [63:0] xi_r [MS];

  generate
    for (s = 0; s < MS; s++) begin : g_xi
      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv[0]) begin
            xi_r[0] <= {in_ch.xi_re, in_ch.xi_im};
          end
        end
      end else begin : g_rest
        always_ff @(posedge clk) begin
          if (adv[s]) begin
            xi_r[s] <= xi_r[s-1];
          end
        end
      end
    end
  endgenerate

  // stage 0: G+k per axis
  logic signed [24:0] s0_x_r, s0_y_r, s0_z_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_x_r <= {in_ch.g_x[23], in_ch.g_x} + {k_x_r[23], k_x_r};
      s0_y_r <= {in_ch.g_y[23], in_ch.g_y} + {k_y_r[23], k_y_r};
      s0_z_r <= {in_ch.g_z[23], in_ch.g_z} + {k_z_r[23], k_z_r};
    end
  end

  // stage 1: squares
  logic signed [49:0] px, py, pz;
  logic [48:0]        s1_x_r, s1_y_r, s1_z_r;

  assign px = s0_x_r * s0_x_r;
  assign py = s0_y_r * s0_y_r;
  assign pz = s0_z_r * s0_z_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_x_r <= px[48:0];
      s1_y_r <= py[48:0];
      s1_z_r <= pz[48:0];
    end
  end

  // stage 2: |G+k|^2
  logic [49:0] dot_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      dot_r <= {1'b0, s1_x_r} + {1'b0, s1_y_r} + {1'b0, s1_z_r};
    end
  end

  // stage 3: partial products with inv_kinetic
  logic [49:0] ph_r;
  logic [63:0] pl_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ph_r <= {32'd0, dot_r[49:32]} * {18'd0, inv_kin_r};
      pl_r <= {32'd0, dot_r[31:0]} * {32'd0, inv_kin_r};
    end
  end

  // stage 4: x with saturation
  logic [56:0] xs;
  logic [31:0] x4s_r;

  assign xs = {ph_r, 7'd0} + {18'd0, pl_r[63:25]};

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      x4s_r <= (|xs[56:32]) ? '1 : xs[31:0];
    end
  end

  // stage 5: x*x
  logic [63:0] xx_r;
  logic [31:0] x5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      xx_r <= {32'd0, x4s_r} * {32'd0, x4s_r};
      x5_r <= x4s_r;
    end
  end

  // stage 6: x^2 times x, split into two products
  logic [39:0] x2_6_r, p3h_r;
  logic [63:0] p3l_r;
  logic [31:0] x6_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      x2_6_r <= xx_r[63:24];
      p3h_r  <= {32'd0, xx_r[63:56]} * {8'd0, x5_r};
      p3l_r  <= {32'd0, xx_r[55:24]} * {32'd0, x5_r};
      x6_r   <= x5_r;
    end
  end

  // stage 7: x^3
  logic [71:0] t3;
  logic [47:0] x3_7_r;
  logic [39:0] x2_7_r;
  logic [31:0] x7_r;

  assign t3 = {p3h_r, 32'd0} + {8'd0, p3l_r};

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      x3_7_r <= t3[71:24];
      x2_7_r <= x2_6_r;
      x7_r   <= x6_r;
    end
  end

  // stage 8: x^3 times x and the numerator
  logic [47:0] p4h_r;
  logic [63:0] p4l_r;
  logic [51:0] num8_r;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      p4h_r  <= {32'd0, x3_7_r[47:32]} * {16'd0, x7_r};
      p4l_r  <= {32'd0, x3_7_r[31:0]} * {32'd0, x7_r};
      num8_r <= kp_pkg::NUM_C27 + 52'(x7_r) * 52'd18 + 52'(x2_7_r) * 52'd12
                + 52'(x3_7_r) * 52'd8;
    end
  end

  // stage 9: x^4
  logic [79:0] t4;
  logic [55:0] x4p_r;
  logic [51:0] num9_r;

  assign t4 = {p4h_r, 32'd0} + {16'd0, p4l_r};

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      x4p_r  <= t4[79:24];
      num9_r <= num8_r;
    end
  end

  // stage 10: denominator, ratio of one when the quartic term vanishes
  logic [60:0] den10_r, num10_r;
  logic        eq10_r;

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      den10_r <= 61'(num9_r) + {1'b0, x4p_r, 4'd0};
      num10_r <= 61'(num9_r);
      eq10_r  <= (x4p_r == '0);
    end
  end

  // divider: one quotient bit per stage
  logic [60:0]   drem_r [DB];
  logic [60:0]   dden_r [DB];
  logic [DB-1:0] dq_r   [DB];
  logic          deq_r  [DB];

  generate
    for (s = 0; s < DB; s++) begin : g_div
      logic [60:0]   rem_in, den_in;
      logic [DB-1:0] q_in;
      logic          eq_in;
      logic [61:0]   sh, diff;
      logic          ge;

      if (s == 0) begin : g_src0
        assign rem_in = num10_r;
        assign den_in = den10_r;
        assign q_in   = '0;
        assign eq_in  = eq10_r;
      end else begin : g_srcn
        assign rem_in = drem_r[s-1];
        assign den_in = dden_r[s-1];
        assign q_in   = dq_r[s-1];
        assign eq_in  = deq_r[s-1];
      end

      assign sh   = {rem_in, 1'b0};
      assign diff = sh - {1'b0, den_in};
      assign ge   = (sh >= {1'b0, den_in});

      always_ff @(posedge clk) begin
        if (adv[DS+s]) begin
          drem_r[s] <= ge ? diff[60:0] : sh[60:0];
          dden_r[s] <= den_in;
          dq_r[s]   <= {q_in[DB-2:0], ge};
          deq_r[s]  <= eq_in;
        end
      end
    end
  endgenerate

  // complex scaling by the ratio
  logic [30:0]        ratio;
  logic signed [31:0] ratio_s;
  logic signed [31:0] xr, xq;
  logic signed [62:0] prod_re_r, prod_im_r;

  assign ratio   = deq_r[DB-1] ? kp_pkg::RATIO_ONE : {1'b0, dq_r[DB-1]};
  assign ratio_s = {1'b0, ratio};
  assign xr      = xi_r[MS-1][63:32];
  assign xq      = xi_r[MS-1][31:0];

  always_ff @(posedge clk) begin
    if (adv[MS]) begin
      prod_re_r <= 63'(ratio_s) * 63'(xr);
      prod_im_r <= 63'(ratio_s) * 63'(xq);
    end
  end

  // output register, floor by arithmetic shift
  logic signed [62:0] sh_re, sh_im;
  logic [31:0]        eta_re_r, eta_im_r;

  assign sh_re = prod_re_r >>> 30;
  assign sh_im = prod_im_r >>> 30;

  always_ff @(posedge clk) begin
    if (adv[OS]) begin
      eta_re_r <= sh_re[31:0];
      eta_im_r <= sh_im[31:0];
    end
  end

  assign out_ch.valid  = v_r[OS];
  assign out_ch.eta_re = eta_re_r;
  assign out_ch.eta_im = eta_im_r;

`ifndef SYNTH
  // an input transfer always fills the first stage
  a_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v_r[0])
    else $error("input transfer did not reach the first stage");

  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[MS-1] && !deq_r[DB-1] |-> drem_r[DB-1] < dden_r[DB-1])
    else $error("divider remainder not below divisor");

  // a stalled product stage holds its item
  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[MS] && !adv[MS] |=> v_r[MS] && $stable(prod_re_r) && $stable(prod_im_r))
    else $error("stalled product stage lost its item");
`endif

endmodule
